// ===== rtl/pfre_pkg.sv =====
// Shared types and constants for the page frame replacement engine.
`timescale 1ns / 1ps
package pfre_pkg;

    localparam int FRAMES            = 64;
    localparam int PROCESSES         = 16;
    localparam int PAGES_PER_PROCESS = 64;

    localparam int FRAME_W = 6;
    localparam int PID_W   = 4;
    localparam int PAGE_W  = 6;
    localparam int CNT_W   = 7;
    localparam int PM_AW   = PID_W + PAGE_W;
    localparam int PM_DEPTH = PROCESSES * PAGES_PER_PROCESS;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    localparam logic [2:0] ST_CREATED  = 3'd0;
    localparam logic [2:0] ST_HIT      = 3'd1;
    localparam logic [2:0] ST_FILL     = 3'd2;
    localparam logic [2:0] ST_REPLACED = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;
    localparam logic [2:0] ST_UNKNOWN  = 3'd5;
    localparam logic [2:0] ST_TOOLARGE = 3'd6;
    localparam logic [2:0] ST_EXISTS   = 3'd7;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_PSIZE  = 2'd1;
    localparam logic [1:0] CFG_FRAMES = 2'd2;

    localparam logic [1:0] MODE_RECENCY = 2'd0;
    localparam logic [1:0] MODE_REFSCAN = 2'd1;
    localparam logic [1:0] MODE_CLOCK   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  process_id;
        logic [21:0] size_kb;
        logic [21:0] address;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] frame;
        logic [6:0] page_count;
        logic       swap_in;
        logic       victim_valid;
        logic [3:0] victim_process;
        logic [5:0] victim_page;
        logic       victim_to_swap;
    } rsp_t;

endpackage

// ===== rtl/page_frame_replacement_engine.sv =====
// Top level of the page frame replacement engine: sequencer, divider and tables.
`timescale 1ns / 1ps
// One request at a time: a bit-serial divider turns the size or address into
// pages, then a sequencer walks the tables one entry at a time. A hit reads
// the page table once; a fault scans for a free frame and, if none is found,
// runs the clock or reference scan over the managed frames, or for process
// recency eviction reads the page tables of the queued processes in order.
// Create clears its 64-entry page table slice. After reset a clearing pass runs
// over all 1024 entries of the page table memory before the first request is
// taken; configuration writes are taken at any time.
module page_frame_replacement_engine
    import pfre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  req_t       in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output rsp_t       out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [16:0] cfg_data
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DIV, S_DECODE, S_CRCLR, S_QPA, S_MAPRD, S_MAPCHK,
        S_FREE, S_VIC2, S_VIC1, S_V0P, S_V0R, S_V0C, S_VRD, S_VEV, S_QREM,
        S_FILLW, S_QPB, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  mode_reg;
    logic [16:0] psize_reg;
    logic [6:0]  nfr_reg;

    req_t        req_reg, req_next;
    logic [21:0] dvd_reg, dvd_next;
    logic [17:0] rem_reg, rem_next;
    logic [4:0]  dcnt_reg, dcnt_next;

    logic [CNT_W-1:0] pages_reg [PROCESSES];
    logic [CNT_W-1:0] pages_next [PROCESSES];
    logic [CNT_W-1:0] mcnt_reg [PROCESSES];
    logic [CNT_W-1:0] mcnt_next [PROCESSES];
    logic [PID_W-1:0] q_reg [PROCESSES];
    logic [PID_W-1:0] q_next [PROCESSES];
    logic [4:0]       qlen_reg, qlen_next;

    logic [FRAMES-1:0] used_reg, used_next;
    logic [FRAMES-1:0] refd_reg, refd_next;
    logic [FRAMES-1:0] dirty_reg, dirty_next;
    logic [FRAME_W-1:0] hand_reg, hand_next;

    logic [6:0]        f_reg, f_next;
    logic [6:0]        g_reg, g_next;
    logic [4:0]        qi_reg, qi_next;
    logic [PID_W-1:0]  vp_reg, vp_next;
    logic [PAGE_W-1:0] pg_reg, pg_next;
    logic              swp_reg, swp_next;
    logic [PM_AW-1:0]  clr_reg, clr_next;

    rsp_t rsp_reg, rsp_next;
    logic ovalid_reg, ovalid_next;

    logic [7:0]       pm_mem [PM_DEPTH];
    logic [7:0]       pm_rdata;
    logic [PM_AW-1:0] pm_raddr, pm_waddr;
    logic [7:0]       pm_wdata;
    logic             pm_we;

    logic [9:0]         ft_mem [FRAMES];
    logic [9:0]         ft_rdata;
    logic [FRAME_W-1:0] ft_raddr, ft_waddr;
    logic [9:0]         ft_wdata;
    logic               ft_we;

    logic [16:0] ps;
    logic [6:0]  nfr;
    logic [17:0] div_rs;
    logic        div_ge;
    logic [22:0] cnt;
    logic [FRAMES-1:0] low_mask;

    logic [PID_W-1:0] rm_pid;
    logic [PROCESSES-1:0] rm_hit, rm_pre;
    logic [PID_W-1:0] q_rm [PROCESSES];
    logic [4:0]       len_rm;

    logic [PID_W-1:0]   pid;
    logic [FRAME_W-1:0] fi;
    logic [FRAME_W-1:0] vo_page;
    logic [PID_W-1:0]   vo;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ovalid_reg;
    assign out_data  = rsp_reg;

    assign ps  = (psize_reg == 17'd0) ? 17'd1 : psize_reg;
    assign nfr = (nfr_reg == 7'd0) ? 7'd1 :
                 (nfr_reg > 7'(FRAMES)) ? 7'(FRAMES) : nfr_reg;

    assign div_rs = {rem_reg[16:0], dvd_reg[21]};
    assign div_ge = (div_rs >= {1'b0, ps});

    assign pid     = req_reg.process_id;
    assign fi      = f_reg[FRAME_W-1:0];
    assign vo      = ft_rdata[9:6];
    assign vo_page = ft_rdata[5:0];

    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            low_mask[i] = (i < int'(nfr));
        end
    end

    // Page count: at least one page, round up a partial page.
    always_comb
    begin
        if (dvd_reg == 22'd0)
        begin
            cnt = 23'd1;
        end
        else
        begin
            cnt = {1'b0, dvd_reg} + ((rem_reg != 18'd0) ? 23'd1 : 23'd0);
        end
    end

    // Drop one process from the recency queue and close the gap.
    assign rm_pid = (state_reg == S_QREM) ? vp_reg : pid;

    always_comb
    begin
        for (int k = 0; k < PROCESSES; k++)
        begin
            rm_hit[k] = (k < int'(qlen_reg)) && (q_reg[k] == rm_pid);
        end
        rm_pre[0] = rm_hit[0];
        for (int k = 1; k < PROCESSES; k++)
        begin
            rm_pre[k] = rm_pre[k-1] | rm_hit[k];
        end
        for (int k = 0; k < PROCESSES; k++)
        begin
            if (rm_pre[k] && (k < PROCESSES - 1))
            begin
                q_rm[k] = q_reg[k+1];
            end
            else
            begin
                q_rm[k] = q_reg[k];
            end
        end
        len_rm = qlen_reg - {4'd0, rm_pre[PROCESSES-1]};
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        pages_next  = pages_reg;
        mcnt_next   = mcnt_reg;
        q_next      = q_reg;
        qlen_next   = qlen_reg;
        used_next   = used_reg;
        refd_next   = refd_reg;
        dirty_next  = dirty_reg;
        hand_next   = hand_reg;
        f_next      = f_reg;
        g_next      = g_reg;
        qi_next     = qi_reg;
        vp_next     = vp_reg;
        pg_next     = pg_reg;
        swp_next    = swp_reg;
        clr_next    = clr_reg;
        rsp_next    = rsp_reg;
        ovalid_next = ovalid_reg;
        pm_raddr    = {pid, pg_reg};
        pm_waddr    = {pid, pg_reg};
        pm_wdata    = 8'd0;
        pm_we       = 1'b0;
        ft_raddr    = fi;
        ft_waddr    = fi;
        ft_wdata    = {pid, pg_reg};
        ft_we       = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                pm_we    = 1'b1;
                pm_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {PM_AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = in_data;
                    dvd_next  = (in_data.opcode == OP_CREATE) ? in_data.size_kb
                                                              : in_data.address;
                    rem_next  = 18'd0;
                    dcnt_next = 5'd0;
                    rsp_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = div_ge ? (div_rs - {1'b0, ps}) : div_rs;
                dvd_next  = {dvd_reg[20:0], div_ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 5'd21)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_OUT;
                if (req_reg.opcode == OP_CREATE)
                begin
                    if (pages_reg[pid] != '0)
                    begin
                        rsp_next.status = ST_EXISTS;
                    end
                    else if (cnt > 23'(PAGES_PER_PROCESS))
                    begin
                        rsp_next.status = ST_TOOLARGE;
                    end
                    else
                    begin
                        pages_next[pid]     = cnt[CNT_W-1:0];
                        mcnt_next[pid]      = '0;
                        rsp_next.status     = ST_CREATED;
                        rsp_next.page_count = cnt[CNT_W-1:0];
                        g_next              = 7'd0;
                        state_next          = S_CRCLR;
                    end
                end
                else if (req_reg.opcode != OP_READ && req_reg.opcode != OP_WRITE)
                begin
                    rsp_next.status = ST_UNKNOWN;
                end
                else if (pages_reg[pid] == '0)
                begin
                    rsp_next.status = ST_UNKNOWN;
                end
                else if (dvd_reg >= {15'd0, pages_reg[pid]})
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    pg_next    = dvd_reg[PAGE_W-1:0];
                    state_next = S_QPA;
                end
            end
            S_CRCLR:
            begin
                pm_we    = 1'b1;
                pm_waddr = {pid, g_reg[PAGE_W-1:0]};
                g_next   = g_reg + 1'b1;
                if (g_reg == 7'(PAGES_PER_PROCESS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_QPA, S_QPB:
            begin
                q_next = q_rm;
                if (len_rm < 5'(PROCESSES))
                begin
                    q_next[len_rm[PID_W-1:0]] = pid;
                    qlen_next = len_rm + 1'b1;
                end
                else
                begin
                    qlen_next = len_rm;
                end
                state_next = (state_reg == S_QPA) ? S_MAPRD : S_OUT;
            end
            S_MAPRD:
            begin
                state_next = S_MAPCHK;
            end
            S_MAPCHK:
            begin
                if (pm_rdata[7])
                begin
                    refd_next[pm_rdata[5:0]] = 1'b1;
                    if (req_reg.opcode == OP_WRITE)
                    begin
                        dirty_next[pm_rdata[5:0]] = 1'b1;
                    end
                    rsp_next.status = ST_HIT;
                    rsp_next.frame  = pm_rdata[5:0];
                    state_next      = S_OUT;
                end
                else
                begin
                    swp_next   = pm_rdata[6];
                    f_next     = 7'd0;
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                if (f_reg < nfr)
                begin
                    if (!used_reg[fi])
                    begin
                        rsp_next.status = ST_FILL;
                        state_next      = S_FILLW;
                    end
                    else
                    begin
                        f_next = f_reg + 1'b1;
                    end
                end
                else if (mode_reg == MODE_RECENCY)
                begin
                    qi_next    = 5'd0;
                    state_next = S_V0P;
                end
                else if (mode_reg == MODE_REFSCAN)
                begin
                    f_next     = 7'd0;
                    state_next = S_VIC1;
                end
                else
                begin
                    if ({1'b0, hand_reg} >= nfr)
                    begin
                        hand_next = '0;
                    end
                    state_next = S_VIC2;
                end
            end
            S_VIC2:
            begin
                hand_next = ({1'b0, hand_reg} + 7'd1 >= nfr) ? '0 : hand_reg + 1'b1;
                if (refd_reg[hand_reg])
                begin
                    refd_next[hand_reg] = 1'b0;
                end
                else
                begin
                    f_next     = {1'b0, hand_reg};
                    state_next = S_VRD;
                end
            end
            S_VIC1:
            begin
                if (!refd_reg[fi])
                begin
                    state_next = S_VRD;
                end
                else if (f_reg + 7'd1 >= nfr)
                begin
                    // no unreferenced frame: clear every managed bit, take frame 0
                    refd_next  = refd_reg & ~low_mask;
                    f_next     = 7'd0;
                    state_next = S_VRD;
                end
                else
                begin
                    f_next = f_reg + 1'b1;
                end
            end
            S_V0P:
            begin
                if (qi_reg >= qlen_reg)
                begin
                    f_next     = 7'd0;
                    state_next = S_VRD;
                end
                else
                begin
                    vp_next    = q_reg[qi_reg[PID_W-1:0]];
                    g_next     = 7'd0;
                    state_next = S_V0R;
                end
            end
            S_V0R:
            begin
                pm_raddr = {vp_reg, g_reg[PAGE_W-1:0]};
                if (g_reg >= pages_reg[vp_reg] || g_reg >= 7'(PAGES_PER_PROCESS))
                begin
                    qi_next    = qi_reg + 1'b1;
                    state_next = S_V0P;
                end
                else
                begin
                    state_next = S_V0C;
                end
            end
            S_V0C:
            begin
                if (pm_rdata[7] && ({1'b0, pm_rdata[5:0]} < nfr))
                begin
                    f_next     = {1'b0, pm_rdata[5:0]};
                    state_next = S_VRD;
                end
                else
                begin
                    g_next     = g_reg + 1'b1;
                    state_next = S_V0R;
                end
            end
            S_VRD:
            begin
                state_next = S_VEV;
            end
            S_VEV:
            begin
                pm_we    = 1'b1;
                pm_waddr = {vo, vo_page};
                pm_wdata = {1'b0, dirty_reg[fi], 6'd0};
                rsp_next.status         = ST_REPLACED;
                rsp_next.victim_valid   = 1'b1;
                rsp_next.victim_process = vo;
                rsp_next.victim_page    = vo_page;
                rsp_next.victim_to_swap = dirty_reg[fi];
                vp_next = vo;
                if (mcnt_reg[vo] != '0)
                begin
                    mcnt_next[vo] = mcnt_reg[vo] - 1'b1;
                end
                state_next = (mcnt_reg[vo] <= 7'd1) ? S_QREM : S_FILLW;
            end
            S_QREM:
            begin
                q_next     = q_rm;
                qlen_next  = len_rm;
                state_next = S_FILLW;
            end
            S_FILLW:
            begin
                pm_we    = 1'b1;
                pm_wdata = {1'b1, 1'b0, fi};
                ft_we    = 1'b1;
                used_next[fi]  = 1'b1;
                refd_next[fi]  = 1'b1;
                dirty_next[fi] = (req_reg.opcode == OP_WRITE);
                mcnt_next[pid] = mcnt_reg[pid] + 1'b1;
                rsp_next.frame   = fi;
                rsp_next.swap_in = swp_reg;
                state_next = S_QPB;
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                if (ovalid_reg && out_ready)
                begin
                    ovalid_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            mode_reg   <= MODE_CLOCK;
            psize_reg  <= 17'd8;
            nfr_reg    <= 7'd64;
            qlen_reg   <= '0;
            used_reg   <= '0;
            refd_reg   <= '0;
            dirty_reg  <= '0;
            hand_reg   <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            rsp_reg    <= '0;
            for (int i = 0; i < PROCESSES; i++)
            begin
                pages_reg[i] <= '0;
                mcnt_reg[i]  <= '0;
                q_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            qlen_reg   <= qlen_next;
            used_reg   <= used_next;
            refd_reg   <= refd_next;
            dirty_reg  <= dirty_next;
            hand_reg   <= hand_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            rsp_reg    <= rsp_next;
            pages_reg  <= pages_next;
            mcnt_reg   <= mcnt_next;
            q_reg      <= q_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:   mode_reg  <= (cfg_data[1:0] == 2'd3) ? MODE_CLOCK
                                                                      : cfg_data[1:0];
                    CFG_PSIZE:  psize_reg <= cfg_data;
                    CFG_FRAMES: nfr_reg   <= cfg_data[6:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dcnt_reg <= dcnt_next;
        f_reg   <= f_next;
        g_reg   <= g_next;
        qi_reg  <= qi_next;
        vp_reg  <= vp_next;
        pg_reg  <= pg_next;
        swp_reg <= swp_next;
    end

    always_ff @(posedge clk)
    begin
        if (pm_we)
        begin
            pm_mem[pm_waddr] <= pm_wdata;
        end
        pm_rdata <= pm_mem[pm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ft_we)
        begin
            ft_mem[ft_waddr] <= ft_wdata;
        end
        ft_rdata <= ft_mem[ft_raddr];
    end

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while a response is pending");

    a_qlen: assert property (@(posedge clk) disable iff (!rst_n)
        qlen_reg <= 5'(PROCESSES))
        else $error("recency queue overflow");

    a_victim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.victim_valid |-> out_data.status == ST_REPLACED)
        else $error("victim reported without replacement");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_FILL || out_data.status == ST_REPLACED)
        |-> {1'b0, out_data.frame} < nfr)
        else $error("filled frame outside the managed range");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the page frame replacement engine.
`timescale 1ns / 1ps
module tb;
    import pfre_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    req_t        in_data;
    logic        out_valid;
    logic        out_ready;
    rsp_t        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    page_frame_replacement_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct {
        bit       used;
        bit       dirty;
        bit       refd;
        bit [3:0] owner;
        bit [5:0] page;
    } frame_entry_t;

    // Local copy of the engine's tables
    bit [1:0]     sel_mode;
    bit [16:0]    sel_psize;
    bit [6:0]     sel_frames;
    int unsigned  pages_of [PROCESSES];
    bit           mapped [PM_DEPTH];
    bit [5:0]     mapped_frame [PM_DEPTH];
    bit           swapped [PM_DEPTH];
    int unsigned  swap_total [PROCESSES];
    frame_entry_t frames [FRAMES];
    int unsigned  hand;
    int unsigned  lru [$];

    req_t         pending_requests [$];
    rsp_t         expected_responses [$];
    int           error_count;
    int           cycle_count;
    bit           idle_free;
    bit           in_taken;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report(input string msg);
        $display("tb: mismatch: %s", msg);
        error_count++;
    endtask

    function automatic void lru_drop(input int unsigned p);
        int idx [$];
        idx = lru.find_index(x) with (x == p);
        foreach (idx[i]) lru.delete(idx[idx.size() - 1 - i]);
    endfunction

    function automatic void lru_touch(input int unsigned p);
        lru_drop(p);
        lru.push_back(p);
    endfunction

    function automatic bit holds_page(input int unsigned p);
        for (int g = 0; g < pages_of[p] && g < PAGES_PER_PROCESS; g++)
            if (mapped[p * PAGES_PER_PROCESS + g]) return 1;
        return 0;
    endfunction

    function automatic int unsigned choose_victim(input int unsigned mode,
                                                  input int unsigned n);
        int unsigned f;
        if (mode == MODE_RECENCY) begin
            foreach (lru[i])
                for (int g = 0; g < pages_of[lru[i]] && g < PAGES_PER_PROCESS; g++)
                    if (mapped[lru[i] * PAGES_PER_PROCESS + g] &&
                        mapped_frame[lru[i] * PAGES_PER_PROCESS + g] < n)
                        return mapped_frame[lru[i] * PAGES_PER_PROCESS + g];
            return 0;
        end
        if (mode == MODE_REFSCAN) begin
            for (int k = 0; k < n; k++)
                if (!frames[k].refd) return k;
            for (int k = 0; k < n; k++) frames[k].refd = 0;
            return 0;
        end
        if (hand >= n) hand = 0;
        for (int k = 0; k < 2 * n + 1; k++) begin
            f = hand;
            hand = (f + 1 >= n) ? 0 : f + 1;
            if (frames[f].refd) frames[f].refd = 0;
            else return f;
        end
        return hand;
    endfunction

    function automatic rsp_t translate_request(input req_t r);
        rsp_t        o;
        int unsigned ps, cnt, pg, slot, n, mode, f, vo, vg;
        o = '0;
        ps = (sel_psize == 0) ? 1 : sel_psize;
        if (r.opcode == 2'd3) begin
            o.status = ST_UNKNOWN;
        end
        else if (r.opcode == OP_CREATE) begin
            cnt = r.size_kb / ps;
            if (cnt < 1) cnt = 1;
            else if (r.size_kb % ps != 0) cnt++;
            if (pages_of[r.process_id] != 0) o.status = ST_EXISTS;
            else if (cnt > PAGES_PER_PROCESS) o.status = ST_TOOLARGE;
            else begin
                pages_of[r.process_id] = cnt;
                for (int g = 0; g < PAGES_PER_PROCESS; g++) begin
                    mapped[r.process_id * PAGES_PER_PROCESS + g] = 0;
                    swapped[r.process_id * PAGES_PER_PROCESS + g] = 0;
                end
                swap_total[r.process_id] = 0;
                o.status = ST_CREATED;
                o.page_count = 7'(cnt);
            end
        end
        else if (pages_of[r.process_id] == 0) begin
            o.status = ST_UNKNOWN;
        end
        else begin
            pg = r.address / ps;
            if (pg >= pages_of[r.process_id]) begin
                o.status = ST_RANGE;
            end
            else begin
                slot = r.process_id * PAGES_PER_PROCESS + pg;
                n = (sel_frames == 0) ? 1 : (sel_frames > FRAMES ? FRAMES : sel_frames);
                mode = (sel_mode > 2) ? 2 : sel_mode;
                lru_touch(r.process_id);
                if (mapped[slot]) begin
                    f = mapped_frame[slot];
                    frames[f].refd = 1;
                    if (r.opcode == OP_WRITE) frames[f].dirty = 1;
                    o.status = ST_HIT;
                end
                else begin
                    for (f = 0; f < n; f++)
                        if (!frames[f].used) break;
                    if (f < n) begin
                        o.status = ST_FILL;
                    end
                    else begin
                        f = choose_victim(mode, n);
                        vo = frames[f].owner;
                        vg = frames[f].page;
                        mapped[vo * PAGES_PER_PROCESS + vg] = 0;
                        if (frames[f].dirty) begin
                            swapped[vo * PAGES_PER_PROCESS + vg] = 1;
                            if (swap_total[vo] < 127) swap_total[vo]++;
                            o.victim_to_swap = 1'b1;
                        end
                        o.victim_valid = 1'b1;
                        o.victim_process = 4'(vo);
                        o.victim_page = 6'(vg);
                        if (!holds_page(vo)) lru_drop(vo);
                        o.status = ST_REPLACED;
                    end
                    if (swapped[slot]) begin
                        swapped[slot] = 0;
                        if (swap_total[r.process_id] > 0) swap_total[r.process_id]--;
                        o.swap_in = 1'b1;
                    end
                    frames[f].used = 1;
                    frames[f].refd = 1;
                    frames[f].dirty = (r.opcode == OP_WRITE);
                    frames[f].owner = r.process_id;
                    frames[f].page = 6'(pg);
                    mapped[slot] = 1;
                    mapped_frame[slot] = 6'(f);
                    lru_touch(r.process_id);
                end
                o.frame = 6'(f);
            end
        end
        return o;
    endfunction

    function automatic req_t make_request(input logic [1:0] op, input logic [3:0] pid,
                                          input logic [21:0] size, input logic [21:0] addr);
        req_t r;
        r.opcode = op;
        r.process_id = pid;
        r.size_kb = size;
        r.address = addr;
        return r;
    endfunction

    // Driver: requests change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (pending_requests.size() > 0 && (idle_free || $urandom_range(99) >= 6))
                begin
                    in_data  <= pending_requests[0];
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= idle_free || ($urandom_range(99) >= 6);
        end
    end

    // Take requests off the queue and predict on acceptance
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            expected_responses.push_back(translate_request(pending_requests[0]));
            pending_requests.pop_front();
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_responses.size() == 0)
                report("response with none expected");
            else begin
                e = expected_responses.pop_front();
                if (out_data.status !== e.status)
                    report($sformatf("status %0d exp %0d", out_data.status, e.status));
                if (out_data.frame !== e.frame)
                    report($sformatf("frame %0d exp %0d", out_data.frame, e.frame));
                if (out_data.page_count !== e.page_count)
                    report($sformatf("page_count %0d exp %0d",
                                     out_data.page_count, e.page_count));
                if (out_data.swap_in !== e.swap_in)
                    report($sformatf("swap_in %0d exp %0d", out_data.swap_in, e.swap_in));
                if (out_data.victim_valid !== e.victim_valid)
                    report($sformatf("victim_valid %0d exp %0d",
                                     out_data.victim_valid, e.victim_valid));
                if (out_data.victim_process !== e.victim_process)
                    report($sformatf("victim_process %0d exp %0d",
                                     out_data.victim_process, e.victim_process));
                if (out_data.victim_page !== e.victim_page)
                    report($sformatf("victim_page %0d exp %0d",
                                     out_data.victim_page, e.victim_page));
                if (out_data.victim_to_swap !== e.victim_to_swap)
                    report($sformatf("victim_to_swap %0d exp %0d",
                                     out_data.victim_to_swap, e.victim_to_swap));
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycle_count > 30000000) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MODE) sel_mode = value[1:0];
        else if (idx == CFG_PSIZE) sel_psize = value;
        else sel_frames = value[6:0];
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || expected_responses.size() > 0)
            @(posedge clk);
        // let the last handshake settle
        repeat (4) @(posedge clk);
    endtask

    // Mostly reads and writes to random processes, some creates and noise
    task automatic queue_random(input int count, input int unsigned psize);
        int unsigned k;
        logic [3:0]  pid;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            pid = 4'($urandom_range(15));
            if (k < 6)
                pending_requests.push_back(make_request(OP_CREATE, pid,
                    22'($urandom_range(psize * 20)), 22'd0));
            else if (k < 9)
                pending_requests.push_back(make_request(2'($urandom), pid,
                    22'($urandom), 22'($urandom)));
            else if (k < 12)
                pending_requests.push_back(make_request(OP_READ, pid, 22'd0,
                    22'($urandom_range(4194303))));
            else
                pending_requests.push_back(make_request(
                    $urandom_range(1) ? OP_READ : OP_WRITE, pid, 22'($urandom),
                    22'($urandom_range(psize * 24))));
        end
    endtask

    initial
    begin
        logic [16:0] ps_set [4];
        logic [6:0]  fr_set [4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        idle_free = 1'b0;
        in_taken = 1'b0;
        sel_mode = MODE_CLOCK;
        sel_psize = 8;
        sel_frames = 64;
        hand = 0;
        foreach (pages_of[i]) pages_of[i] = 0;
        foreach (swap_total[i]) swap_total[i] = 0;
        foreach (mapped[i]) begin
            mapped[i] = 0;
            mapped_frame[i] = 0;
            swapped[i] = 0;
        end
        foreach (frames[i]) frames[i] = '{0, 0, 0, 0, 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: edges, bad ops, range limits, too large, exists
        pending_requests.push_back(make_request(OP_READ, 4'd3, 0, 0));
        pending_requests.push_back(make_request(2'd3, 4'd0, 22'h3FFFFF, 22'h3FFFFF));
        pending_requests.push_back(make_request(OP_CREATE, 4'd0, 0, 0));
        pending_requests.push_back(make_request(OP_CREATE, 4'd0, 8, 0));
        pending_requests.push_back(make_request(OP_CREATE, 4'd1, 512, 0));
        pending_requests.push_back(make_request(OP_CREATE, 4'd2, 513, 0));
        pending_requests.push_back(make_request(OP_CREATE, 4'd15, 22'h3FFFFF, 0));
        pending_requests.push_back(make_request(OP_CREATE, 4'd15, 9, 0));
        pending_requests.push_back(make_request(OP_WRITE, 4'd0, 0, 7));
        pending_requests.push_back(make_request(OP_READ, 4'd0, 0, 8));
        pending_requests.push_back(make_request(OP_READ, 4'd1, 0, 511));
        pending_requests.push_back(make_request(OP_WRITE, 4'd1, 0, 512));
        pending_requests.push_back(make_request(OP_READ, 4'd15, 0, 15));
        pending_requests.push_back(make_request(OP_READ, 4'd0, 22'h3FFFFF, 0));
        pending_requests.push_back(make_request(OP_WRITE, 4'd15, 0, 22'h3FFFFF));
        drain();

        // Phases: every mode, page sizes and frame counts including extremes
        ps_set = '{17'd1, 17'd8, 17'd0, 17'h1FFFF};
        fr_set = '{7'd1, 7'd4, 7'd0, 7'd127};
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_MODE, 17'(ph % 4));
            write_reg(CFG_PSIZE, (ph == 11) ? 17'd65536 : ps_set[ph % 4 == 3 ? 1 : ph % 3]);
            write_reg(CFG_FRAMES, (ph == 10) ? 17'd64 : {10'd0, fr_set[(ph / 3) % 4]});
            idle_free = (ph == 5);
            if (ph == 0) begin
                pending_requests.push_back(make_request(OP_READ, 4'd1, 0, 22'h3FFFFF));
                pending_requests.push_back(make_request(OP_CREATE, 4'd4, 22'h3FFFFF, 0));
            end
            queue_random(140, (sel_psize == 0) ? 1 : (sel_psize > 4096 ? 4096 : sel_psize));
            drain();
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/pfre_pkg.sv
rtl/page_frame_replacement_engine.sv
test/tb.sv
